>>> hw/rtl/diff_drive_odometry_defines.svh
// Assertion macros for the odometry block.
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`ifndef SYNTHESIS
`define DDO_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define DDO_ASSERT_RST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DDO_ASSERT(label, clk, rst_n, prop)
`define DDO_ASSERT_RST(label, clk, prop)
`endif
`endif

>>> hw/rtl/ddo_pkg.sv
// Package for the odometry block: widths, constants, angle table, phase codes.
`default_nettype none
package ddo_pkg;
	localparam int CordicSteps = 20;
	localparam int StepW = 5;
	localparam logic [31:0] DistReset = 32'd449768;
	localparam logic [31:0] AngleReset = 32'd550637;
	localparam logic [63:0] CordicGain = 64'd652032874;
	localparam logic [31:0] TwoPiQ16 = 32'd411775;
	localparam logic [0:0] RegDist = 1'b0;
	localparam logic [0:0] RegAngle = 1'b1;

	typedef enum logic [6:0] {
		PH_IDLE = 7'b0000001,
		PH_MUL  = 7'b0000010,
		PH_ROT  = 7'b0000100,
		PH_POS  = 7'b0001000,
		PH_DIV  = 7'b0010000,
		PH_SCL  = 7'b0100000,
		PH_OUT  = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic start;
		logic busy;
	} ctl_t;

	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B; 5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53; 5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001; default: r = 32'h00000000;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/ddo_if.sv
// Valid/ready channel interfaces for input and result beats.
`default_nettype none
interface ddo_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] left_ticks;
	logic signed [15:0] right_ticks;
	logic [31:0] now_ms;
	modport source(output valid, left_ticks, right_ticks, now_ms, input ready);
	modport sink(input valid, left_ticks, right_ticks, now_ms, output ready);
endinterface

interface ddo_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [31:0] heading;
	logic signed [31:0] lin_vel;
	logic signed [31:0] ang_vel;
	logic elapsed_zero;
	modport source(output valid, pos_x, pos_y, heading, lin_vel, ang_vel, elapsed_zero,
		input ready);
	modport sink(input valid, pos_x, pos_y, heading, lin_vel, ang_vel, elapsed_zero,
		output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ddo_mul.sv
// Serial shift-add multiplier: unsigned 64 x 32, one multiplier bit per cycle.
`default_nettype none
module ddo_mul (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ddo_pkg::ctl_t ctl,
	input  wire logic [63:0] a,
	input  wire logic [31:0] b,
	output logic [95:0] p,
	output logic done
);
	logic [95:0] acc_q;
	logic [31:0] mb_q;
	logic [5:0] cnt_q;
	logic run_q;

	// one partial product per cycle, LSB of multiplier first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd31) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			mb_q <= b;
		end else if (run_q) begin
			if (mb_q[0]) acc_q <= acc_q + ({32'd0, a} << cnt_q[4:0]);
			mb_q <= mb_q >> 1;
		end
	end

	assign p = acc_q;
	assign done = ctl.busy && !run_q && !ctl.start;
endmodule
`default_nettype wire

>>> hw/rtl/ddo_div.sv
// Restoring divider: 64-bit dividend by 49-bit divisor, one quotient bit per cycle.
`default_nettype none
module ddo_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ddo_pkg::ctl_t ctl,
	input  wire logic [63:0] num,
	input  wire logic [48:0] den,
	output logic [63:0] quo,
	output logic done
);
	logic [63:0] q_q;
	logic [49:0] r_q;
	logic [48:0] d_q;
	logic [6:0] cnt_q;
	logic [49:0] trial;

	assign trial = {r_q[48:0], q_q[63]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (ctl.start) cnt_q <= 7'd64;
		else if (cnt_q != 7'd0) cnt_q <= cnt_q - 7'd1;
	end

	// shift one dividend bit into the remainder, subtract if it fits
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (cnt_q != 7'd0) begin
			if (!trial[49]) begin
				r_q <= trial;
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= {r_q[48:0], q_q[63]};
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
	assign done = ctl.busy && cnt_q == 7'd0 && !ctl.start;
endmodule
`default_nettype wire

>>> hw/rtl/ddo_cordic.sv
// Iterative CORDIC: cosine and sine of a binary angle, Q22, one rotation per cycle.
`default_nettype none
module ddo_cordic (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ddo_pkg::ctl_t ctl,
	input  wire logic [31:0] angle,
	output logic signed [33:0] cos_q22,
	output logic signed [33:0] sin_q22,
	output logic done
);
	logic signed [33:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic flip_q;
	logic [ddo_pkg::StepW:0] i_q;
	logic run_q;
	logic [31:0] u;
	logic flip;
	logic signed [33:0] xs, ys, xn, yn;
	logic [31:0] at;

	assign flip = angle[31] ^ angle[30];
	assign u = flip ? angle + 32'h80000000 : angle;
	assign xs = x_q >>> i_q[4:0];
	assign ys = y_q >>> i_q[4:0];
	assign at = ddo_pkg::atan_bam(i_q[4:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			i_q <= '0;
		end else if (ctl.start) begin
			run_q <= 1'b1;
			i_q <= '0;
		end else if (run_q) begin
			i_q <= i_q + (ddo_pkg::StepW + 1)'(1);
			if (i_q == (ddo_pkg::StepW + 1)'(ddo_pkg::CordicSteps - 1)) run_q <= 1'b0;
		end
	end

	// one micro-rotation per cycle
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= 34'(ddo_pkg::CordicGain);
			y_q <= '0;
			z_q <= 34'(signed'(u));
			flip_q <= flip;
		end else if (run_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - 34'(at);
			end else begin
				x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + 34'(at);
			end
		end
	end

	assign xn = flip_q ? -x_q : x_q;
	assign yn = flip_q ? -y_q : y_q;
	assign cos_q22 = xn >>> 8;
	assign sin_q22 = yn >>> 8;
	assign done = ctl.busy && !run_q && !ctl.start;
endmodule
`default_nettype wire

>>> hw/rtl/diff_drive_odometry.sv
// Differential-drive odometry: top level with sequencer and state.
// Sequence: two tick products, 20 CORDIC rotations, two position products, two divisions
//   and one scale product; at zero elapsed time the divisions and the scale are skipped,
//   and when the angular quotient is too large to scale the scale product is skipped.
// Flow: the result sits in the output register and the next item is taken the cycle
//   after it leaves, so output stalls hold off the next item.
// Reset (arst_n, async): position, heading and last time go to zero, registers to defaults.
`default_nettype none
`include "diff_drive_odometry_defines.svh"
module diff_drive_odometry (
	input  wire logic clk,
	input  wire logic arst_n,
	ddo_in_if.sink  in_ch,
	ddo_out_if.source out_ch,
	input  wire logic cfg_we,
	input  wire logic [0:0] cfg_idx,
	input  wire logic [31:0] cfg_wdata
);
	ddo_pkg::phase_t ph_q;
	logic [2:0] sub_q;
	logic [31:0] dist_q, angle_q, hd_q, last_q, dt_q;
	logic signed [31:0] x_q, y_q;
	logic signed [16:0] s_q, t_q;
	logic [63:0] dmag_q, amag_q;
	logic dneg_q, aneg_q;
	logic signed [33:0] c_q, sn_q;
	logic signed [31:0] lin_q, ang_q;
	logic ez_q, ov_q;
	logic ddo_st, mul_st, div_st;
	logic [63:0] mul_a;
	logic [31:0] mul_b;
	logic [95:0] mul_p;
	logic mul_done, cor_done, div_done;
	logic [63:0] div_num, div_quo;
	logic [48:0] div_den;
	logic signed [33:0] cos_w, sin_w;
	logic [63:0] dq24m;
	logic pneg;
	logic signed [65:0] pstep;
	logic signed [33:0] psum;
	logic [31:0] qsat;
	logic signed [32:0] lsign;

	ddo_pkg::ctl_t mul_ctl, cor_ctl, div_ctl;
	assign mul_ctl = '{start: mul_st, busy: ph_q == ddo_pkg::PH_MUL || ph_q == ddo_pkg::PH_POS
		|| ph_q == ddo_pkg::PH_SCL};
	assign cor_ctl = '{start: ddo_st, busy: ph_q == ddo_pkg::PH_ROT};
	assign div_ctl = '{start: div_st, busy: ph_q == ddo_pkg::PH_DIV};

	ddo_mul u_mul (.clk, .arst_n, .ctl(mul_ctl), .a(mul_a), .b(mul_b), .p(mul_p),
		.done(mul_done));
	ddo_cordic u_cor (.clk, .arst_n, .ctl(cor_ctl), .angle(hd_q), .cos_q22(cos_w),
		.sin_q22(sin_w), .done(cor_done));
	ddo_div u_div (.clk, .arst_n, .ctl(div_ctl), .num(div_num), .den(div_den),
		.quo(div_quo), .done(div_done));

	// magnitude of floor(D/2^9)
	assign dq24m = dneg_q ? ((dmag_q - 64'd1) >> 9) + 64'd1 : dmag_q >> 9;
	logic [33:0] trig;
	assign trig = (sub_q[0] ? sn_q : c_q);
	logic [33:0] trigm;
	assign trigm = trig[33] ? -trig : trig;
	assign pneg = dneg_q ^ trig[33];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ph_q)
			ddo_pkg::PH_MUL: begin
				mul_a = sub_q[0] ? 64'(t_q[16] ? -t_q : t_q) : 64'(s_q[16] ? -s_q : s_q);
				mul_b = sub_q[0] ? angle_q : dist_q;
			end
			ddo_pkg::PH_POS: begin
				mul_a = dq24m;
				mul_b = trigm[31:0];
			end
			ddo_pkg::PH_SCL: begin
				mul_a = {19'd0, div_quo[44:0]};
				mul_b = ddo_pkg::TwoPiQ16;
			end
			default: ;
		endcase
	end

	// exact floor of signed product / 2^30 from magnitude
	assign pstep = pneg ? -66'(((mul_p - 96'd1) >> 30) + 96'd1) : 66'(mul_p >> 30);
	assign psum = 34'(sub_q[0] ? y_q : x_q) + 34'(pstep[33:0]);

	// dividends: |D|*1000 over dt<<17, |A|*1000 over dt
	assign div_num = sub_q[0] ? amag_q * 64'd1000 : dmag_q * 64'd1000;
	assign div_den = sub_q[0] ? 49'(dt_q) : {dt_q, 17'd0};
	assign qsat = (div_quo > 64'hFFFFFFFF) ? 32'hFFFFFFFF : div_quo[31:0];
	assign lsign = dneg_q ? -33'(qsat) : 33'(qsat);

	assign in_ch.ready = ph_q == ddo_pkg::PH_IDLE;
	assign out_ch.valid = ph_q == ddo_pkg::PH_OUT;
	assign out_ch.pos_x = x_q;
	assign out_ch.pos_y = y_q;
	assign out_ch.heading = hd_q;
	assign out_ch.lin_vel = lin_q;
	assign out_ch.ang_vel = ang_q;
	assign out_ch.elapsed_zero = ez_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= ddo_pkg::DistReset;
			angle_q <= ddo_pkg::AngleReset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ddo_pkg::RegDist: dist_q <= cfg_wdata;
				ddo_pkg::RegAngle: angle_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign ddo_st = ph_q == ddo_pkg::PH_MUL && sub_q[1] && mul_done;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= ddo_pkg::PH_IDLE;
			sub_q <= '0;
			x_q <= '0; y_q <= '0; hd_q <= '0; last_q <= '0;
			mul_st <= 1'b0; div_st <= 1'b0;
		end else begin
			mul_st <= 1'b0;
			div_st <= 1'b0;
			unique case (ph_q)
				ddo_pkg::PH_IDLE: if (in_ch.valid) begin
					s_q <= 17'(in_ch.left_ticks) + 17'(in_ch.right_ticks);
					t_q <= 17'(in_ch.right_ticks) - 17'(in_ch.left_ticks);
					dt_q <= in_ch.now_ms - last_q;
					last_q <= in_ch.now_ms;
					ph_q <= ddo_pkg::PH_MUL;
					sub_q <= '0;
					mul_st <= 1'b1;
				end
				ddo_pkg::PH_MUL: if (mul_done && !mul_st) begin
					if (!sub_q[0]) begin
						dmag_q <= mul_p[63:0];
						dneg_q <= s_q[16] && mul_p != '0;
						sub_q <= 3'd1;
						mul_st <= 1'b1;
					end else if (!sub_q[1]) begin
						amag_q <= mul_p[63:0];
						aneg_q <= t_q[16] && mul_p != '0;
						hd_q <= hd_q + (t_q[16] ? -mul_p[31:0] : mul_p[31:0]);
						sub_q <= 3'd3;
					end else begin
						ph_q <= ddo_pkg::PH_ROT;
						sub_q <= '0;
					end
				end
				ddo_pkg::PH_ROT: if (cor_done) begin
					c_q <= cos_w;
					sn_q <= sin_w;
					ph_q <= ddo_pkg::PH_POS;
					sub_q <= '0;
					mul_st <= 1'b1;
				end
				ddo_pkg::PH_POS: if (mul_done && !mul_st) begin
					if (!sub_q[0]) begin
						x_q <= (psum > 34'sh7FFFFFFF) ? 32'sh7FFFFFFF :
							(psum < -34'sh80000000) ? 32'sh80000000 : psum[31:0];
						sub_q <= 3'd1;
						mul_st <= 1'b1;
					end else begin
						y_q <= (psum > 34'sh7FFFFFFF) ? 32'sh7FFFFFFF :
							(psum < -34'sh80000000) ? 32'sh80000000 : psum[31:0];
						sub_q <= '0;
						ez_q <= dt_q == '0;
						if (dt_q == '0) begin
							lin_q <= '0; ang_q <= '0;
							ph_q <= ddo_pkg::PH_OUT;
						end else begin
							ph_q <= ddo_pkg::PH_DIV;
							div_st <= 1'b1;
						end
					end
				end
				ddo_pkg::PH_DIV: if (div_done && !div_st) begin
					if (!sub_q[0]) begin
						lin_q <= (lsign > 33'sh7FFFFFFF) ? 32'sh7FFFFFFF :
							(lsign < -33'sh80000000) ? 32'sh80000000 : lsign[31:0];
						sub_q <= 3'd1;
						div_st <= 1'b1;
					end else begin
						ov_q <= div_quo[63:45] != '0;
						ph_q <= ddo_pkg::PH_SCL;
						mul_st <= div_quo[63:45] == '0;
					end
				end
				ddo_pkg::PH_SCL: if (ov_q) begin
					ang_q <= aneg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
					ph_q <= ddo_pkg::PH_OUT;
				end else if (mul_done && !mul_st) begin
					// rv = (q*TwoPi)>>32 with q < 2^45
					ang_q <= (mul_p[95:63] != '0) ? (aneg_q ? 32'sh80000000 : 32'sh7FFFFFFF) :
						(aneg_q ? -$signed(mul_p[63:32]) : $signed(mul_p[63:32]));
					ph_q <= ddo_pkg::PH_OUT;
				end
				ddo_pkg::PH_OUT: if (out_ch.ready) ph_q <= ddo_pkg::PH_IDLE;
				default: ph_q <= ddo_pkg::PH_IDLE;
			endcase
		end
	end

	`DDO_ASSERT(a_ready_idle, clk, arst_n, in_ch.ready |-> !out_ch.valid)
	`DDO_ASSERT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.pos_x))
	`DDO_ASSERT(a_ez_zero, clk, arst_n, out_ch.valid && out_ch.elapsed_zero |-> out_ch.lin_vel == 32'sd0 && out_ch.ang_vel == 32'sd0)
endmodule
`default_nettype wire
